// ===== design/kaes_pkg.sv =====
// Shared types, constants and small functions for the keypad angle entry block.
// Depends on nothing; every other design file but kaes_chan_if refers to it by scoped names.

package kaes_pkg;

   // Digit code for a place that has not been entered yet
   localparam logic [3:0] DIGIT_EMPTY = 4'd10;

   // Full-scale angle in degrees
   localparam logic [7:0] ANGLE_MAX = 8'd180;

   // Reset values of the configuration registers
   localparam logic [7:0] MIN_TICKS_RESET  = 8'd10;
   localparam logic [7:0] SPAN_TICKS_RESET = 8'd10;

   // Configuration register indexes
   localparam logic [0:0] CSR_PULSE_MIN  = 1'b0;
   localparam logic [0:0] CSR_PULSE_SPAN = 1'b1;

   // Command codes
   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_HOLD = 1'b1;

   // Division by 180: drop two bits, then multiply by the reciprocal of 45.
   // Exact for every quotient input below 2^14 since 14 bits * 7 < 2^19.
   localparam int         QUOT_SHIFT = 19;
   localparam logic [13:0] QUOT_MULT  = 14'd11651;

   // Input word: one key or button press
   typedef struct packed {
      logic       command;
      logic [1:0] key_row;
      logic [1:0] key_col;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [3:0] digit_units;
      logic [3:0] digit_tens;
      logic [3:0] digit_hundreds;
      logic       held;
      logic [7:0] angle_deg;
      logic [7:0] pulse_ticks;
      logic       pulse_update;
      logic [7:0] seg_units;
      logic [7:0] seg_tens;
      logic [7:0] seg_hundreds;
   } rsp_word_type;

   // Configuration write word
   typedef struct packed {
      logic [0:0] reg_index;
      logic [7:0] data;
   } csr_word_type;

   // Entry stage to pulse stage
   typedef struct packed {
      logic [3:0]  digit_units;
      logic [3:0]  digit_tens;
      logic [3:0]  digit_hundreds;
      logic        held;
      logic [7:0]  angle_deg;
      logic [15:0] product;
      logic        changed;
      logic [7:0]  min_ticks;
   } stage_word_type;

   // Numeric value of a digit code; empty and stray codes count as zero
   function automatic logic [3:0] digit_value(input logic [3:0] d);
      digit_value = (d < 4'd10) ? d : 4'd0;
   endfunction

   // Common-anode seven-segment pattern; empty shows as zero
   function automatic logic [7:0] digit_segments(input logic [3:0] d);
      case (d)
         4'd1:    digit_segments = 8'hF9;
         4'd2:    digit_segments = 8'hA4;
         4'd3:    digit_segments = 8'hB0;
         4'd4:    digit_segments = 8'h99;
         4'd5:    digit_segments = 8'h92;
         4'd6:    digit_segments = 8'h82;
         4'd7:    digit_segments = 8'hF8;
         4'd8:    digit_segments = 8'h80;
         4'd9:    digit_segments = 8'h98;
         default: digit_segments = 8'hC0;
      endcase
   endfunction

   // Key position to digit; the bottom row gives zero, column 3 reads as column 2
   function automatic logic [3:0] key_digit(input logic [1:0] row, input logic [1:0] col);
      logic [1:0] c;
      c = (col == 2'd3) ? 2'd2 : col;
      if (row == 2'd3) begin
         key_digit = 4'd0;
      end else begin
         key_digit = 4'({2'b00, row} * 4'd3) + 4'({2'b00, c}) + 4'd1;
      end
   endfunction

endpackage

// ===== design/kaes_chan_if.sv =====
// Valid/ready channel carrying one payload word per handshake.
// The payload type is set per instance from kaes_pkg types.

interface kaes_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/kaes_csr_regs.sv =====
// Configuration registers: pulse width at zero angle and span up to full angle.
// Depends on kaes_pkg for the word type, indexes and reset values.

module kaes_csr_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  write_fire,
   input  kaes_pkg::csr_word_type write_word,
   output logic [7:0]            min_ticks,
   output logic [7:0]            span_ticks
);

   logic [7:0] min_ticks_ff;
   logic [7:0] span_ticks_ff;

   // Load the addressed register on a completed write
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ticks_ff  <= kaes_pkg::MIN_TICKS_RESET;
         span_ticks_ff <= kaes_pkg::SPAN_TICKS_RESET;
      end else if (write_fire) begin
         unique case (write_word.reg_index)
            kaes_pkg::CSR_PULSE_MIN:  min_ticks_ff  <= write_word.data;
            kaes_pkg::CSR_PULSE_SPAN: span_ticks_ff <= write_word.data;
         endcase
      end
   end

   assign min_ticks  = min_ticks_ff;
   assign span_ticks = span_ticks_ff;

endmodule

// ===== design/kaes_entry.sv =====
// Entry stage: digit and hold state, angle, span product and change flag.
// Depends on kaes_pkg for the word types, digit codes and helper functions.

module kaes_entry (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_fire,
   input  kaes_pkg::req_word_type  in_word,
   input  logic [7:0]              min_ticks,
   input  logic [7:0]              span_ticks,
   input  logic                    advance,
   output logic                    stage_valid,
   output kaes_pkg::stage_word_type stage_word
);

   logic [3:0]       units_ff, tens_ff, hundreds_ff;
   logic [3:0]       units_in, tens_in, hundreds_in;
   logic             hold_ff, hold_in;
   logic [2:0][3:0]  saved_ff, saved_in;
   logic [7:0]       last_angle_ff;
   logic             stage_valid_ff, stage_valid_in;
   kaes_pkg::stage_word_type stage_word_ff, stage_word_in;

   logic [3:0]  key_value;
   logic        restart;
   logic [3:0]  base_units, base_tens, base_hundreds;
   logic [9:0]  angle_sum;
   logic [7:0]  angle;

   // Entry clears before the shift once all three places are filled
   assign key_value     = kaes_pkg::key_digit(in_word.key_row, in_word.key_col);
   assign restart       = (hundreds_ff != kaes_pkg::DIGIT_EMPTY);
   assign base_units    = restart ? kaes_pkg::DIGIT_EMPTY : units_ff;
   assign base_tens     = restart ? kaes_pkg::DIGIT_EMPTY : tens_ff;
   assign base_hundreds = restart ? kaes_pkg::DIGIT_EMPTY : hundreds_ff;

   // Next digit and hold state for this word
   always_comb begin
      units_in    = units_ff;
      tens_in     = tens_ff;
      hundreds_in = hundreds_ff;
      hold_in     = hold_ff;
      saved_in    = saved_ff;
      if (in_word.command == kaes_pkg::CMD_HOLD) begin
         if (!hold_ff) begin
            saved_in    = {hundreds_ff, tens_ff, units_ff};
            units_in    = 4'd0;
            tens_in     = 4'd0;
            hundreds_in = 4'd0;
            hold_in     = 1'b1;
         end else begin
            units_in    = saved_ff[0];
            tens_in     = saved_ff[1];
            hundreds_in = saved_ff[2];
            hold_in     = 1'b0;
         end
      end else if (!hold_ff) begin
         if (base_units == kaes_pkg::DIGIT_EMPTY) begin
            units_in    = key_value;
            tens_in     = base_tens;
            hundreds_in = base_hundreds;
         end else if (base_tens == kaes_pkg::DIGIT_EMPTY) begin
            units_in    = key_value;
            tens_in     = base_units;
            hundreds_in = base_hundreds;
         end else begin
            units_in    = key_value;
            tens_in     = base_units;
            hundreds_in = base_tens;
         end
      end
   end

   // Angle from the new digits, clamped to full scale
   assign angle_sum = 10'(kaes_pkg::digit_value(units_in))
                    + 10'(kaes_pkg::digit_value(tens_in)) * 10'd10
                    + 10'(kaes_pkg::digit_value(hundreds_in)) * 10'd100;
   assign angle     = (angle_sum > 10'(kaes_pkg::ANGLE_MAX)) ? kaes_pkg::ANGLE_MAX
                                                            : angle_sum[7:0];

   // Build the stage word
   always_comb begin
      stage_word_in.digit_units    = units_in;
      stage_word_in.digit_tens     = tens_in;
      stage_word_in.digit_hundreds = hundreds_in;
      stage_word_in.held           = hold_in;
      stage_word_in.angle_deg      = angle;
      stage_word_in.product        = 16'(angle) * 16'(span_ticks);
      stage_word_in.changed        = (angle != last_angle_ff);
      stage_word_in.min_ticks      = min_ticks;
   end

   // Stage is full after an accept, empties when the word moves on
   assign stage_valid_in = in_fire | (stage_valid_ff & ~advance);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff       <= kaes_pkg::DIGIT_EMPTY;
         tens_ff        <= kaes_pkg::DIGIT_EMPTY;
         hundreds_ff    <= kaes_pkg::DIGIT_EMPTY;
         hold_ff        <= 1'b0;
         saved_ff       <= '0;
         last_angle_ff  <= 8'd0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (in_fire) begin
            units_ff      <= units_in;
            tens_ff       <= tens_in;
            hundreds_ff   <= hundreds_in;
            hold_ff       <= hold_in;
            saved_ff      <= saved_in;
            last_angle_ff <= angle;
         end
      end
   end

   // Hold the stage word until the next accept
   always_ff @(posedge clock) begin
      if (in_fire) begin
         stage_word_ff <= stage_word_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_word  = stage_word_ff;

endmodule

// ===== design/kaes_pulse.sv =====
// Pulse stage: divide the span product by 180, add and saturate, map segments.
// Depends on kaes_pkg for the word types, reciprocal constants and segment table.

module kaes_pulse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   input  kaes_pkg::stage_word_type stage_word,
   input  logic                     out_free,
   output logic                     rsp_valid,
   output kaes_pkg::rsp_word_type   rsp_word
);

   logic [13:0] quot_in_val;
   logic [27:0] quot_full;
   logic [7:0]  quotient;
   logic [8:0]  pulse_sum;
   logic        rsp_valid_ff, rsp_valid_in;
   kaes_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Product / 180 as (product / 4) * reciprocal of 45
   assign quot_in_val = stage_word.product[15:2];
   assign quot_full   = 28'(quot_in_val) * 28'(kaes_pkg::QUOT_MULT);
   assign quotient    = quot_full[kaes_pkg::QUOT_SHIFT +: 8];
   assign pulse_sum   = 9'(stage_word.min_ticks) + 9'(quotient);

   // Assemble the result word
   always_comb begin
      rsp_word_in.digit_units    = stage_word.digit_units;
      rsp_word_in.digit_tens     = stage_word.digit_tens;
      rsp_word_in.digit_hundreds = stage_word.digit_hundreds;
      rsp_word_in.held           = stage_word.held;
      rsp_word_in.angle_deg      = stage_word.angle_deg;
      rsp_word_in.pulse_ticks    = pulse_sum[8] ? 8'hFF : pulse_sum[7:0];
      rsp_word_in.pulse_update   = stage_word.changed;
      rsp_word_in.seg_units      = kaes_pkg::digit_segments(stage_word.digit_units);
      rsp_word_in.seg_tens       = kaes_pkg::digit_segments(stage_word.digit_tens);
      rsp_word_in.seg_hundreds   = kaes_pkg::digit_segments(stage_word.digit_hundreds);
   end

   // Output register reloads whenever it is empty or being taken
   assign rsp_valid_in = out_free ? stage_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && stage_valid) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== design/keypad_angle_entry_servo_pulse.sv =====
// Top level of the keypad angle entry block with servo pulse output.
// Depends on kaes_pkg, kaes_chan_if, kaes_csr_regs, kaes_entry and kaes_pulse.
//
//   channel   modport  word                    handshake
//   req_chan  sink     command, key row/col    valid & ready
//   rsp_chan  source   digits, angle, pulse    valid & ready
//   csr_chan  sink     register index, data    valid & ready (ready always high)
//
// From accept to result a word passes the entry register, holding the new digits,
// the angle and the span product, then the output register, holding the divided
// and saturated pulse value. One word is accepted per cycle while the result side
// keeps taking. A stalled result holds both stages; the request side then stalls
// only once the entry stage is also full. Reset is synchronous and needs no sweep.

module keypad_angle_entry_servo_pulse (
   input  logic         clock,
   input  logic         reset,
   kaes_chan_if.sink    req_chan,
   kaes_chan_if.source  rsp_chan,
   kaes_chan_if.sink    csr_chan
);

   kaes_pkg::req_word_type   req_word;
   kaes_pkg::csr_word_type   csr_word;
   kaes_pkg::stage_word_type stage_word;
   kaes_pkg::rsp_word_type   rsp_word;

   logic       in_fire;
   logic       csr_fire;
   logic       stage_valid;
   logic       rsp_valid;
   logic       out_free;
   logic       advance;
   logic       req_ready;
   logic [7:0] min_ticks;
   logic [7:0] span_ticks;

   assign req_word = req_chan.payload;
   assign csr_word = csr_chan.payload;

   // Pipeline flow control
   assign out_free  = ~rsp_valid | rsp_chan.ready;
   assign advance   = stage_valid & out_free;
   assign req_ready = ~stage_valid | out_free;
   assign in_fire   = req_chan.valid & req_ready;
   assign csr_fire  = csr_chan.valid;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   kaes_csr_regs u_csr (
      .clock      (clock),
      .reset      (reset),
      .write_fire (csr_fire),
      .write_word (csr_word),
      .min_ticks  (min_ticks),
      .span_ticks (span_ticks)
   );

   kaes_entry u_entry (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .in_word     (req_word),
      .min_ticks   (min_ticks),
      .span_ticks  (span_ticks),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_word  (stage_word)
   );

   kaes_pulse u_pulse (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_word  (stage_word),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_word;

endmodule
